/* hw/rtl/page_cache_round_robin_writeback_top_assert.svh */
// Assertion macros for the page cache top level.
// Needs clk and rst_n in the scope of use.
`ifndef PAGE_CACHE_ROUND_ROBIN_WRITEBACK_TOP_ASSERT_SVH
`define PAGE_CACHE_ROUND_ROBIN_WRITEBACK_TOP_ASSERT_SVH

// same-cycle implication
`define PCRR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcrr assertion failed");

// next-cycle implication
`define PCRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcrr assertion failed");

`endif

/* hw/rtl/pcrr_pkg.sv */
// Shared types and constants for the round-robin write-back page cache.
// No dependencies.
package pcrr_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int PTR_W         = $clog2(CACHE_ENTRIES);
    localparam int OFFSET_W      = 31;
    localparam int HANDLE_W      = 16;

    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [HANDLE_W-1:0] handle_t;

    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_INSERT  = 2'd1,
        OP_QOFFSET = 2'd2,
        OP_QHANDLE = 2'd3
    } op_t;

    typedef struct packed {
        op_t     opcode;
        offset_t page_offset;
        handle_t page_handle;
        logic    will_be_dirty;
    } req_t;

    typedef struct packed {
        logic    hit;
        handle_t found_handle;
        logic    evict_valid;
        offset_t evict_offset;
        handle_t evict_handle;
    } rsp_t;

    // transaction state handed from cell to cell
    typedef struct packed {
        req_t req;
        ptr_t target;
        rsp_t rsp;
    } carry_t;

endpackage

/* hw/rtl/pcrr_cell.sv */
// One cache entry of the cell chain; processes the passing transaction
// and registers it for the next cell. Depends on pcrr_pkg.
module pcrr_cell
    import pcrr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  ptr_t   idx,
    input  logic   in_valid,
    input  carry_t in_carry,
    output logic   out_valid,
    output carry_t out_carry
);

    offset_t offset_reg, offset_next;
    handle_t handle_reg, handle_next;
    logic    valid_reg, valid_next;
    logic    dirty_reg, dirty_next;
    logic    out_valid_reg;
    carry_t  carry_reg, carry_next;
    logic    match_off;
    logic    match_hdl;

    assign match_off = valid_reg && (offset_reg == in_carry.req.page_offset);
    assign match_hdl = valid_reg && (handle_reg == in_carry.req.page_handle);

    always_comb
    begin
        offset_next = offset_reg;
        handle_next = handle_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        carry_next  = in_carry;
        if (in_valid)
        begin
            unique case (in_carry.req.opcode)
                OP_LOOKUP:
                begin
                    if (!in_carry.rsp.hit && match_off)
                    begin
                        carry_next.rsp.hit          = 1'b1;
                        carry_next.rsp.found_handle = handle_reg;
                        dirty_next = dirty_reg | in_carry.req.will_be_dirty;
                    end
                end
                OP_INSERT:
                begin
                    if (in_carry.target == idx)
                    begin
                        if (valid_reg && dirty_reg)
                        begin
                            carry_next.rsp.evict_valid  = 1'b1;
                            carry_next.rsp.evict_offset = offset_reg;
                            carry_next.rsp.evict_handle = handle_reg;
                        end
                        offset_next = in_carry.req.page_offset;
                        handle_next = in_carry.req.page_handle;
                        valid_next  = 1'b1;
                        dirty_next  = in_carry.req.will_be_dirty;
                    end
                end
                OP_QOFFSET:
                begin
                    if (match_off)
                    begin
                        carry_next.rsp.hit = 1'b1;
                    end
                end
                OP_QHANDLE:
                begin
                    if (match_hdl)
                    begin
                        carry_next.rsp.hit = 1'b1;
                    end
                end
                default:
                begin
                    carry_next = in_carry;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            dirty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= offset_next;
        handle_reg <= handle_next;
        carry_reg  <= carry_next;
    end

    assign out_valid = out_valid_reg;
    assign out_carry = carry_reg;

endmodule

/* hw/rtl/page_cache_round_robin_writeback_top.sv */
// Top level of the round-robin write-back page cache: chain of entry cells.
// Depends on pcrr_pkg, pcrr_cell and page_cache_round_robin_writeback_top_assert.svh.
//
// A transaction is taken when start is high and busy is low. It walks the
// chain of CACHE_ENTRIES cells, one cell per clock, each cell registering
// it, so its result shows on rsp with done high for one cycle; the receiver
// cannot stall it. busy drops in the done cycle, so a new transaction can be
// taken only once the last one has walked through the whole cell chain.
`include "page_cache_round_robin_writeback_top_assert.svh"

module page_cache_round_robin_writeback_top
    import pcrr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    logic                     accept;
    logic                     busy_reg, busy_next;
    ptr_t                     ptr_reg, ptr_next;
    ptr_t                     ptr_inc;
    carry_t                   head;
    logic   [CACHE_ENTRIES-1:0] chain_valid;
    carry_t                   chain_carry [CACHE_ENTRIES];

    assign accept  = start && !busy_reg;
    assign ptr_inc = (ptr_reg == ptr_t'(CACHE_ENTRIES - 1)) ? '0 : ptr_reg + 1'b1;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (accept && (req.opcode == OP_INSERT))
        begin
            ptr_next = ptr_inc;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (chain_valid[CACHE_ENTRIES-2])
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        head.req    = req;
        head.target = ptr_inc;
        head.rsp    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ptr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ptr_reg  <= ptr_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CACHE_ENTRIES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                pcrr_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .idx       (ptr_t'(gi)),
                    .in_valid  (accept),
                    .in_carry  (head),
                    .out_valid (chain_valid[gi]),
                    .out_carry (chain_carry[gi])
                );
            end
            else
            begin : g_rest
                pcrr_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .idx       (ptr_t'(gi)),
                    .in_valid  (chain_valid[gi-1]),
                    .in_carry  (chain_carry[gi-1]),
                    .out_valid (chain_valid[gi]),
                    .out_carry (chain_carry[gi])
                );
            end
        end
    endgenerate

    assign busy = busy_reg;
    assign done = chain_valid[CACHE_ENTRIES-1];
    assign rsp  = chain_carry[CACHE_ENTRIES-1].rsp;

    `PCRR_ASSERT_NOW(a_one_in_flight, 1'b1, $onehot0(chain_valid))
    `PCRR_ASSERT_NEXT(a_busy_after_accept, accept, busy)
    `PCRR_ASSERT_NOW(a_idle_chain_empty, !busy_reg, chain_valid[CACHE_ENTRIES-2:0] == '0)
    `PCRR_ASSERT_NEXT(a_single_done, done, !done)

endmodule

/* tb/tb.sv */
// Self-checking testbench for the round-robin write-back page cache top level.
// Depends on pcrr_pkg and page_cache_round_robin_writeback_top.
// Directed cases first, then random traffic; results are checked against a shadow cache.
module tb;
    import pcrr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int POOL_SIZE      = 16;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    page_cache_round_robin_writeback_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // shadow copy of the cache contents
    offset_t shadow_offset [CACHE_ENTRIES];
    handle_t shadow_handle [CACHE_ENTRIES];
    logic    shadow_valid  [CACHE_ENTRIES];
    logic    shadow_dirty  [CACHE_ENTRIES];
    int      shadow_ptr;

    rsp_t    pending_rsp[$];
    offset_t offset_pool [POOL_SIZE];
    handle_t handle_pool [POOL_SIZE];

    int sender_idle_pct;
    int mismatch_count;
    int accepted_count;
    int result_count;
    int hit_count;
    int evict_count;
    int stall_cycles;

    function automatic int first_offset_match(offset_t off);
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (shadow_valid[i] && shadow_offset[i] == off)
                return i;
        return -1;
    endfunction

    function automatic int first_handle_match(handle_t h);
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (shadow_valid[i] && shadow_handle[i] == h)
                return i;
        return -1;
    endfunction

    function automatic rsp_t cache_predict(req_t r);
        rsp_t o;
        int   k;
        o = '0;
        case (r.opcode)
            OP_LOOKUP:
            begin
                k = first_offset_match(r.page_offset);
                if (k >= 0)
                begin
                    o.hit          = 1'b1;
                    o.found_handle = shadow_handle[k];
                    shadow_dirty[k] = shadow_dirty[k] | r.will_be_dirty;
                end
            end
            OP_INSERT:
            begin
                shadow_ptr = (shadow_ptr + 1) % CACHE_ENTRIES;
                if (shadow_valid[shadow_ptr] && shadow_dirty[shadow_ptr])
                begin
                    o.evict_valid  = 1'b1;
                    o.evict_offset = shadow_offset[shadow_ptr];
                    o.evict_handle = shadow_handle[shadow_ptr];
                end
                shadow_offset[shadow_ptr] = r.page_offset;
                shadow_handle[shadow_ptr] = r.page_handle;
                shadow_valid[shadow_ptr]  = 1'b1;
                shadow_dirty[shadow_ptr]  = r.will_be_dirty;
            end
            OP_QOFFSET:
                o.hit = (first_offset_match(r.page_offset) >= 0);
            default:
                o.hit = (first_handle_match(r.page_handle) >= 0);
        endcase
        return o;
    endfunction

    // acceptance, result check and watchdog
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        logic bad;
        if (rst_n)
        begin
            if (done)
            begin
                result_count++;
                if (pending_rsp.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: hit=%0d fh=%h ev=%0d eo=%h eh=%h",
                                 rsp.hit, rsp.found_handle, rsp.evict_valid,
                                 rsp.evict_offset, rsp.evict_handle);
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    bad = (rsp.hit !== exp_rsp.hit)
                       || (rsp.found_handle !== exp_rsp.found_handle)
                       || (rsp.evict_valid !== exp_rsp.evict_valid)
                       || (rsp.evict_offset !== exp_rsp.evict_offset)
                       || (rsp.evict_handle !== exp_rsp.evict_handle);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result %0d wrong: exp hit=%0d fh=%h ev=%0d eo=%h eh=%h",
                                     result_count, exp_rsp.hit, exp_rsp.found_handle,
                                     exp_rsp.evict_valid, exp_rsp.evict_offset,
                                     exp_rsp.evict_handle);
                            $display("    got hit=%0d fh=%h ev=%0d eo=%h eh=%h",
                                     rsp.hit, rsp.found_handle, rsp.evict_valid,
                                     rsp.evict_offset, rsp.evict_handle);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                exp_rsp = cache_predict(req);
                pending_rsp.push_back(exp_rsp);
                accepted_count++;
                if (exp_rsp.hit)
                    hit_count++;
                if (exp_rsp.evict_valid)
                    evict_count++;
            end
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // returns at the edge that accepts the transaction, start still high
    task automatic send_request(req_t r);
        logic taken;
        taken = 1'b0;
        req <= r;
        while (!taken)
        begin
            if ($urandom_range(99) < sender_idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                start <= 1'b1;
                @(posedge clk);
                taken = !busy;
            end
        end
    endtask

    function automatic req_t make_request(op_t op, offset_t off, handle_t h, logic wd);
        req_t r;
        r.opcode        = op;
        r.page_offset   = off;
        r.page_handle   = h;
        r.will_be_dirty = wd;
        return r;
    endfunction

    task automatic test_empty_cache();
        send_request(make_request(OP_LOOKUP,  '0, '0, 1'b1));
        send_request(make_request(OP_QOFFSET, '0, '0, 1'b0));
        send_request(make_request(OP_QHANDLE, '1, '0, 1'b0));
    endtask

    task automatic test_insert_and_lookup();
        send_request(make_request(OP_INSERT,  '1, '1, 1'b1));
        send_request(make_request(OP_INSERT,  '0, '0, 1'b0));
        send_request(make_request(OP_LOOKUP,  '1, '0, 1'b0));
        send_request(make_request(OP_LOOKUP,  '0, '1, 1'b0));
        send_request(make_request(OP_QOFFSET, '0, '1, 1'b1));
        send_request(make_request(OP_QHANDLE, '1, '0, 1'b0));
        send_request(make_request(OP_QHANDLE, '1, '1, 1'b1));
    endtask

    // duplicate offset: lowest slot wins, lookup only ever sets dirty
    task automatic test_duplicates();
        send_request(make_request(OP_INSERT, '0, 16'h1234, 1'b1));
        send_request(make_request(OP_LOOKUP, '0, '0, 1'b1));
        send_request(make_request(OP_LOOKUP, '0, '0, 1'b0));
    endtask

    task automatic test_wraparound_eviction();
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            if (i % 2 == 0)
                send_request(make_request(OP_INSERT, 31'h2AAA_AAAA, 16'h5555, 1'b1));
            else
                send_request(make_request(OP_INSERT, 31'h5555_5555, 16'hAAAA, 1'b0));
        end
        send_request(make_request(OP_QOFFSET, '1, '0, 1'b0));
        send_request(make_request(OP_LOOKUP,  31'h5555_5555, '0, 1'b1));
    endtask

    function automatic req_t random_request();
        req_t r;
        int   roll;
        int   slot;
        roll = $urandom_range(99);
        if (roll < 38)
            r.opcode = OP_INSERT;
        else if (roll < 70)
            r.opcode = OP_LOOKUP;
        else if (roll < 85)
            r.opcode = OP_QOFFSET;
        else
            r.opcode = OP_QHANDLE;
        slot = $urandom_range(POOL_SIZE - 1);
        if ($urandom_range(99) < 75)
        begin
            r.page_offset = offset_pool[slot];
            r.page_handle = handle_pool[slot];
        end
        else
        begin
            r.page_offset = offset_t'($urandom());
            r.page_handle = handle_t'($urandom());
            if (r.opcode == OP_INSERT)
            begin
                offset_pool[slot] = r.page_offset;
                handle_pool[slot] = r.page_handle;
            end
        end
        if ($urandom_range(9) == 0)
            r.page_handle = handle_pool[$urandom_range(POOL_SIZE - 1)];
        r.will_be_dirty = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic test_random_traffic(int count, int idle_pct);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
            send_request(random_request());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        shadow_ptr     = 0;
        mismatch_count = 0;
        accepted_count = 0;
        result_count   = 0;
        hit_count      = 0;
        evict_count    = 0;
        stall_cycles   = 0;
        sender_idle_pct = 32;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            shadow_offset[i] = '0;
            shadow_handle[i] = '0;
            shadow_valid[i]  = 1'b0;
            shadow_dirty[i]  = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            offset_pool[i] = (i == 0) ? '1 : (i == 1) ? '0 : offset_t'($urandom());
            handle_pool[i] = (i == 0) ? '1 : (i == 1) ? '0 : handle_t'($urandom());
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_cache();
        test_insert_and_lookup();
        test_duplicates();
        test_wraparound_eviction();
        test_random_traffic(560, 32);
        test_random_traffic(560, 57);
        test_random_traffic(560, 0);

        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (CACHE_ENTRIES + 4) @(posedge clk);

        if (pending_rsp.size() != 0)
            mismatch_count++;
        $display("covered %0d transactions: %0d hits, %0d dirty write-backs",
                 accepted_count, hit_count, evict_count);
        $display("%0d results checked, %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
